FILE: rtl/core/slpg_pkg.sv
`timescale 1ns / 1ps

package slpg_pkg;

    // Register map indexes (byte address is 4 * index).
    localparam int unsigned APB_ADDR_W = 5;
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_ENABLE      = 3'd1;
    localparam logic [2:0] REG_HB_ON       = 3'd2;
    localparam logic [2:0] REG_HB_OFF      = 3'd3;
    localparam logic [2:0] REG_SETUP_HALF  = 3'd4;
    localparam logic [2:0] REG_PULSE       = 3'd5;
    localparam logic [2:0] REG_CONNECT_GAP = 3'd6;
    localparam logic [2:0] REG_ERROR_GAP   = 3'd7;

    // LED mode codes.
    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_ON        = 3'd1;
    localparam logic [2:0] MODE_HEARTBEAT = 3'd2;
    localparam logic [2:0] MODE_SETUP     = 3'd3;
    localparam logic [2:0] MODE_CONNECT   = 3'd4;
    localparam logic [2:0] MODE_ERROR     = 3'd5;

    // Step at which each pulse train sits in its gap.
    localparam logic [2:0] CONNECT_GAP_STEP = 3'd4;
    localparam logic [2:0] ERROR_GAP_STEP   = 3'd6;

    // Reset values of the registers.
    localparam logic [2:0]  RST_MODE        = MODE_OFF;
    localparam logic        RST_ENABLE      = 1'b1;
    localparam logic [15:0] RST_HB_ON       = 16'd100;
    localparam logic [15:0] RST_HB_OFF      = 16'd900;
    localparam logic [15:0] RST_SETUP_HALF  = 16'd150;
    localparam logic [15:0] RST_PULSE       = 16'd120;
    localparam logic [15:0] RST_CONNECT_GAP = 16'd1200;
    localparam logic [15:0] RST_ERROR_GAP   = 16'd1500;

    // Current register contents.
    typedef struct packed {
        logic [2:0]  led_mode;
        logic        led_enable;
        logic [15:0] heartbeat_on_ms;
        logic [15:0] heartbeat_off_ms;
        logic [15:0] setup_half_ms;
        logic [15:0] pulse_ms;
        logic [15:0] connect_gap_ms;
        logic [15:0] error_gap_ms;
    } slpg_cfg_t;

    // Side effects of register writes on the pattern state.
    typedef struct packed {
        logic mode_write;
        logic disable_write;
    } slpg_cfg_evt_t;

endpackage

FILE: rtl/core/slpg_time_if.sv
`timescale 1ns / 1ps

interface slpg_time_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink (input valid, input now_ms, output ready);
endinterface

FILE: rtl/core/slpg_led_if.sv
`timescale 1ns / 1ps

interface slpg_led_if;
    logic valid;
    logic ready;
    logic led_on;

    modport source (output valid, output led_on, input ready);
    modport sink (input valid, input led_on, output ready);
endinterface

FILE: rtl/core/slpg_regs.sv
`timescale 1ns / 1ps

module slpg_regs
    import slpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output slpg_cfg_t             cfg,
    output slpg_cfg_evt_t         cfg_evt
);

    slpg_cfg_t  cfg_reg;
    slpg_cfg_t  cfg_next;
    logic       wr_en;
    logic [2:0] wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[APB_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_idx)
                REG_MODE:        cfg_next.led_mode         = pwdata[2:0];
                REG_ENABLE:      cfg_next.led_enable       = pwdata[0];
                REG_HB_ON:       cfg_next.heartbeat_on_ms  = pwdata[15:0];
                REG_HB_OFF:      cfg_next.heartbeat_off_ms = pwdata[15:0];
                REG_SETUP_HALF:  cfg_next.setup_half_ms    = pwdata[15:0];
                REG_PULSE:       cfg_next.pulse_ms         = pwdata[15:0];
                REG_CONNECT_GAP: cfg_next.connect_gap_ms   = pwdata[15:0];
                REG_ERROR_GAP:   cfg_next.error_gap_ms     = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Pattern side effects of mode and enable writes.
    assign cfg_evt.mode_write    = wr_en && (wr_idx == REG_MODE);
    assign cfg_evt.disable_write = wr_en && (wr_idx == REG_ENABLE) && !pwdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_mode         <= RST_MODE;
            cfg_reg.led_enable       <= RST_ENABLE;
            cfg_reg.heartbeat_on_ms  <= RST_HB_ON;
            cfg_reg.heartbeat_off_ms <= RST_HB_OFF;
            cfg_reg.setup_half_ms    <= RST_SETUP_HALF;
            cfg_reg.pulse_ms         <= RST_PULSE;
            cfg_reg.connect_gap_ms   <= RST_CONNECT_GAP;
            cfg_reg.error_gap_ms     <= RST_ERROR_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (wr_idx)
            REG_MODE:        prdata = {29'd0, cfg_reg.led_mode};
            REG_ENABLE:      prdata = {31'd0, cfg_reg.led_enable};
            REG_HB_ON:       prdata = {16'd0, cfg_reg.heartbeat_on_ms};
            REG_HB_OFF:      prdata = {16'd0, cfg_reg.heartbeat_off_ms};
            REG_SETUP_HALF:  prdata = {16'd0, cfg_reg.setup_half_ms};
            REG_PULSE:       prdata = {16'd0, cfg_reg.pulse_ms};
            REG_CONNECT_GAP: prdata = {16'd0, cfg_reg.connect_gap_ms};
            REG_ERROR_GAP:   prdata = {16'd0, cfg_reg.error_gap_ms};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/slpg_engine.sv
`timescale 1ns / 1ps

module slpg_engine
    import slpg_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  slpg_cfg_t     cfg,
    input  slpg_cfg_evt_t cfg_evt,
    input  logic          update,
    input  logic [31:0]   now_ms,
    output logic          led_next
);

    logic                 pin_level_reg;
    logic                 pin_level_next;
    logic                 toggle_level_reg;
    logic                 toggle_level_next;
    logic [2:0]           pattern_step_reg;
    logic [2:0]           pattern_step_next;
    logic [TIME_BITS-1:0] last_time_reg;
    logic [TIME_BITS-1:0] last_time_next;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [15:0]          hb_limit;
    logic                 force_low;
    logic                 pulse_mode;
    logic [2:0]           gap_step;
    logic [15:0]          gap_ms;

    // Timestamp resized to the internal time width.
    generate
        if (TIME_BITS > 32)
        begin : g_wide
            assign now_t = {{(TIME_BITS-32){1'b0}}, now_ms};
        end
        else
        begin : g_narrow
            assign now_t = now_ms[TIME_BITS-1:0];
        end
    endgenerate

    assign elapsed   = now_t - last_time_reg;
    assign hb_limit  = toggle_level_reg ? cfg.heartbeat_on_ms : cfg.heartbeat_off_ms;
    assign force_low = !cfg.led_enable && (cfg.led_mode != MODE_ON)
                       && (cfg.led_mode != MODE_SETUP) && (cfg.led_mode != MODE_ERROR);
    assign pulse_mode = (cfg.led_mode == MODE_CONNECT) || (cfg.led_mode == MODE_ERROR);
    assign gap_step  = (cfg.led_mode == MODE_ERROR) ? ERROR_GAP_STEP : CONNECT_GAP_STEP;
    assign gap_ms    = (cfg.led_mode == MODE_ERROR) ? cfg.error_gap_ms : cfg.connect_gap_ms;

    // Pattern update for one timestamp.
    always_comb
    begin
        pin_level_next    = pin_level_reg;
        toggle_level_next = toggle_level_reg;
        pattern_step_next = pattern_step_reg;
        last_time_next    = last_time_reg;
        if (force_low)
        begin
            pin_level_next = 1'b0;
        end
        else if (cfg.led_mode == MODE_ON)
        begin
            pin_level_next = 1'b1;
        end
        else if (cfg.led_mode == MODE_HEARTBEAT || cfg.led_mode == MODE_SETUP)
        begin
            if (elapsed >= TIME_BITS'((cfg.led_mode == MODE_SETUP)
                                      ? cfg.setup_half_ms : hb_limit))
            begin
                last_time_next    = now_t;
                toggle_level_next = !toggle_level_reg;
                pin_level_next    = !toggle_level_reg;
            end
        end
        else if (pulse_mode)
        begin
            if (pattern_step_reg == 3'd0)
            begin
                pin_level_next    = 1'b1;
                last_time_next    = now_t;
                pattern_step_next = 3'd1;
            end
            else if (pattern_step_reg < gap_step)
            begin
                if (elapsed > TIME_BITS'(cfg.pulse_ms))
                begin
                    pin_level_next    = !pattern_step_reg[0];
                    last_time_next    = now_t;
                    pattern_step_next = pattern_step_reg + 3'd1;
                end
            end
            else if (elapsed > TIME_BITS'(gap_ms))
            begin
                pattern_step_next = 3'd0;
            end
        end
        else
        begin
            pin_level_next = 1'b0;
        end
    end

    assign led_next = pin_level_next;

    // Pattern state; register writes are for the user to make only while idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_level_reg    <= 1'b0;
            toggle_level_reg <= 1'b0;
            pattern_step_reg <= 3'd0;
            last_time_reg    <= '0;
        end
        else if (cfg_evt.mode_write)
        begin
            pin_level_reg    <= 1'b0;
            toggle_level_reg <= 1'b0;
            pattern_step_reg <= 3'd0;
            last_time_reg    <= '0;
        end
        else if (cfg_evt.disable_write)
        begin
            pin_level_reg <= 1'b0;
        end
        else if (update)
        begin
            pin_level_reg    <= pin_level_next;
            toggle_level_reg <= toggle_level_next;
            pattern_step_reg <= pattern_step_next;
            last_time_reg    <= last_time_next;
        end
    end

endmodule

FILE: rtl/core/status_led_pattern_generator_unit.sv
`timescale 1ns / 1ps

// Status LED pattern generator.
// Each transaction on time_in carries a millisecond timestamp (now_ms); the
// block advances the LED pattern selected by the mode register and returns
// one transaction on led_out holding the LED level after that update.
// The pattern state is updated in the cycle the timestamp is accepted, and
// the result is registered into the output register or the skid register.
// Unless the receiver stalls, throughput is one timestamp per cycle: the update
// is one subtract, one compare and a small step transition between the state registers.
// A two-entry output buffer (output register plus skid register) lets a new
// timestamp be accepted while a result waits; time_in.ready drops only when
// both entries are full because the receiver has stalled.
// Registers are written through the APB port at byte address 4 * index and
// must be written only while the block is idle. Writing the mode restarts
// the pattern with the LED low; clearing the enable forces the LED low except in the on, setup and error modes.
// Reset (rst_n low, asynchronous) loads the register defaults, clears the
// pattern state and empties the output buffer.
module status_led_pattern_generator_unit
    import slpg_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    slpg_time_if.sink             time_in,
    slpg_led_if.source            led_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    slpg_cfg_t     cfg;
    slpg_cfg_evt_t cfg_evt;
    logic          in_take;
    logic          out_take;
    logic          led_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_led_reg;
    logic          out_led_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic          skid_led_reg;
    logic          skid_led_next;

    slpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_evt (cfg_evt)
    );

    slpg_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_evt  (cfg_evt),
        .update   (in_take),
        .now_ms   (time_in.now_ms),
        .led_next (led_next)
    );

    assign time_in.ready  = !skid_valid_reg;
    assign in_take        = time_in.valid && !skid_valid_reg;
    assign out_take       = out_valid_reg && led_out.ready;
    assign led_out.valid  = out_valid_reg;
    assign led_out.led_on = out_led_reg;

    // Output buffer: results enter the output register when it frees up,
    // otherwise they wait in the skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_led_next    = out_led_reg;
        skid_valid_next = skid_valid_reg;
        skid_led_next   = skid_led_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_led_next    = skid_led_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_take;
                out_led_next   = led_next;
            end
        end
        else if (in_take)
        begin
            skid_valid_next = 1'b1;
            skid_led_next   = led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_led_reg  <= out_led_next;
        skid_led_reg <= skid_led_next;
    end

endmodule
